FILE: hdl/uart_flash_protocol_server_defines.svh
// Assertion macros shared by the protocol server checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UART_FLASH_PROTOCOL_SERVER_DEFINES_SVH
`define UART_FLASH_PROTOCOL_SERVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define UFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ufps_pkg.sv
// Types and constants of the UART flash protocol server.
// No dependencies; used by the top level and its checker.
package ufps_pkg;

  localparam logic [7:0] HDR_WRITE_CMD  = 8'h57;
  localparam logic [7:0] HDR_TARGET_VER = 8'h56;
  localparam logic [7:0] OP_WRITE       = 8'h01;
  localparam logic [7:0] OP_READ        = 8'h02;
  localparam logic [7:0] OP_ERASE       = 8'h03;
  localparam logic [7:0] ACK_BYTE       = 8'h06;
  localparam logic [7:0] ERASED_BYTE    = 8'hFF;

  localparam int unsigned LIMIT_W = 19;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd135168;

  // Register index decoded from paddr[2]
  localparam logic REG_MEMORY_LIMIT = 1'b0;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_ERASE = 2'd3
  } cmd_t;

  typedef enum logic [11:0] {
    PH_IDLE      = 12'b0000_0000_0001,
    PH_CMD       = 12'b0000_0000_0010,
    PH_ADDR      = 12'b0000_0000_0100,
    PH_LEN       = 12'b0000_0000_1000,
    PH_READ      = 12'b0000_0001_0000,
    PH_WRITE     = 12'b0000_0010_0000,
    PH_VER       = 12'b0000_0100_0000,
    PH_RD_REQ    = 12'b0000_1000_0000,
    PH_RD_DATA   = 12'b0001_0000_0000,
    PH_ERASE     = 12'b0010_0000_0000,
    PH_ERASE_ACK = 12'b0100_0000_0000,
    PH_VER_RPT   = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [31:0] ver;
    logic        last;
  } result_t;

endpackage

FILE: hdl/uart_flash_protocol_server.sv
// UART flash protocol server: byte protocol engine over an emulated byte memory.
// Depends on ufps_pkg.
//
// Usage: each received UART byte is one beat on the in_ channel; every byte
// the host must see comes back as a beat on the out_ channel, marked
// last_of_run on the final beat that one input byte causes. A version report
// (result_kind 1) follows the fourth byte after a 'V' header.
// Results go through a four-entry queue; a new byte is taken while queued
// results wait, as long as two entries are free and the engine is not busy.
// The first result of a byte is queued in the accept cycle and is visible
// in the cycle after. A read data byte passes through the memory request
// state and the registered memory read before its queue write. An erase walks
// the memory one byte per cycle through its single port, and in_ready stays low
// until its ack is queued. A version report is queued from its own state.
// A stalled receiver only fills the queue; in_ready drops once fewer than two
// entries are free.
// Reset returns the engine to idle, empties the queue and restores
// memory_limit. Memory content is not cleared: it holds the preloaded image.
module uart_flash_protocol_server #(
  parameter int unsigned MEM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic [31:0] out_target_version,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned PW = $clog2(MEM_BYTES + 1);
  localparam logic [32:0] MEM_BYTES_EXT = 33'(MEM_BYTES);

  // Configuration
  logic [ufps_pkg::LIMIT_W-1:0] limit_r;
  logic                         cfg_wr;

  // Protocol state
  ufps_pkg::phase_t phase_r, phase_nxt;
  ufps_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [31:0]      ver_r, ver_nxt;

  // Memory
  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata_r;

  // Result queue
  ufps_pkg::result_t fifo_r [4];
  logic [1:0]        wr_ptr_r, rd_ptr_r;
  logic [2:0]        count_r;
  logic              push, pop;
  ufps_pkg::result_t push_item;

  logic          accept;
  logic          accepting;
  logic [32:0]   end_sum;
  logic [32:0]   lim_ext;
  logic          range_ok;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] len_lo;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ufps_pkg::REG_MEMORY_LIMIT);
  assign prdata = (paddr[2] == ufps_pkg::REG_MEMORY_LIMIT) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ufps_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[ufps_pkg::LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  assign accepting = (phase_r == ufps_pkg::PH_IDLE)  || (phase_r == ufps_pkg::PH_CMD)   ||
                     (phase_r == ufps_pkg::PH_ADDR)  || (phase_r == ufps_pkg::PH_LEN)   ||
                     (phase_r == ufps_pkg::PH_READ)  || (phase_r == ufps_pkg::PH_WRITE) ||
                     (phase_r == ufps_pkg::PH_VER);
  // Keep room for both results a byte can cause
  assign in_ready  = accepting && (count_r <= 3'd2);
  assign accept    = in_valid && in_ready;

  assign lim_ext  = (33'(limit_r) < MEM_BYTES_EXT) ? 33'(limit_r) : MEM_BYTES_EXT;
  assign end_sum  = {1'b0, addr_r} + {1'b0, len_nxt};
  assign range_ok = (end_sum <= lim_ext);
  assign pos_inc  = pos_r + 1'b1;
  assign len_lo   = len_r[PW-1:0];
  assign mem_addr = addr_r[AW-1:0] + pos_r[AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    ver_nxt   = ver_r;
    push      = 1'b0;
    push_item = '{kind: ufps_pkg::KIND_TX, tx: ufps_pkg::ACK_BYTE, ver: '0, last: 1'b1};
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = ufps_pkg::ERASED_BYTE;
    if (phase_r == ufps_pkg::PH_LEN && accept) begin
      len_nxt[{cnt_r, 3'b000} +: 8] = in_rx_byte;
    end
    case (phase_r)
      ufps_pkg::PH_IDLE: begin
        if (accept) begin
          if (in_rx_byte == ufps_pkg::HDR_WRITE_CMD) begin
            push      = 1'b1;
            phase_nxt = ufps_pkg::PH_CMD;
          end else if (in_rx_byte == ufps_pkg::HDR_TARGET_VER) begin
            push      = 1'b1;
            ver_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = ufps_pkg::PH_VER;
          end
        end
      end
      ufps_pkg::PH_CMD: begin
        if (accept) begin
          if (in_rx_byte == ufps_pkg::OP_WRITE || in_rx_byte == ufps_pkg::OP_READ ||
              in_rx_byte == ufps_pkg::OP_ERASE) begin
            push      = 1'b1;
            cmd_nxt   = ufps_pkg::cmd_t'(in_rx_byte[1:0]);
            addr_nxt  = '0;
            len_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = ufps_pkg::PH_ADDR;
          end else begin
            phase_nxt = ufps_pkg::PH_IDLE;
          end
        end
      end
      ufps_pkg::PH_ADDR: begin
        if (accept) begin
          addr_nxt[{cnt_r, 3'b000} +: 8] = in_rx_byte;
          push    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            phase_nxt = ufps_pkg::PH_LEN;
          end
        end
      end
      ufps_pkg::PH_LEN: begin
        if (accept) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            phase_nxt = ufps_pkg::PH_IDLE;
            pos_nxt   = '0;
            if (range_ok) begin
              case (cmd_r)
                ufps_pkg::CMD_ERASE: begin
                  push_item.last = 1'b0;
                  phase_nxt = (len_nxt == '0) ? ufps_pkg::PH_ERASE_ACK : ufps_pkg::PH_ERASE;
                end
                ufps_pkg::CMD_READ: begin
                  if (len_nxt != '0) begin
                    push_item.last = 1'b0;
                    phase_nxt = ufps_pkg::PH_RD_REQ;
                  end
                end
                ufps_pkg::CMD_WRITE: begin
                  if (len_nxt != '0) begin
                    phase_nxt = ufps_pkg::PH_WRITE;
                  end
                end
                default: begin
                  phase_nxt = ufps_pkg::PH_IDLE;
                end
              endcase
            end
          end
        end
      end
      ufps_pkg::PH_READ: begin
        // Any host byte acks; the one after the last data byte ends the read
        if (accept) begin
          phase_nxt = (pos_r < len_lo) ? ufps_pkg::PH_RD_REQ : ufps_pkg::PH_IDLE;
        end
      end
      ufps_pkg::PH_RD_REQ: begin
        mem_re    = 1'b1;
        phase_nxt = ufps_pkg::PH_RD_DATA;
      end
      ufps_pkg::PH_RD_DATA: begin
        push         = 1'b1;
        push_item.tx = rdata_r;
        pos_nxt      = pos_inc;
        phase_nxt    = ufps_pkg::PH_READ;
      end
      ufps_pkg::PH_WRITE: begin
        if (accept) begin
          mem_we    = 1'b1;
          mem_wdata = in_rx_byte;
          push      = 1'b1;
          pos_nxt   = pos_inc;
          if (pos_inc == len_lo) begin
            phase_nxt = ufps_pkg::PH_IDLE;
          end
        end
      end
      ufps_pkg::PH_ERASE: begin
        mem_we  = 1'b1;
        pos_nxt = pos_inc;
        if (pos_inc == len_lo) begin
          phase_nxt = ufps_pkg::PH_ERASE_ACK;
        end
      end
      ufps_pkg::PH_ERASE_ACK: begin
        push      = 1'b1;
        phase_nxt = ufps_pkg::PH_IDLE;
      end
      ufps_pkg::PH_VER: begin
        if (accept) begin
          ver_nxt[{cnt_r, 3'b000} +: 8] = in_rx_byte;
          push           = 1'b1;
          push_item.last = (cnt_r != 2'd3);
          cnt_nxt        = cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            phase_nxt = ufps_pkg::PH_VER_RPT;
          end
        end
      end
      ufps_pkg::PH_VER_RPT: begin
        push      = 1'b1;
        push_item = '{kind: ufps_pkg::KIND_REPORT, tx: '0, ver: ver_r, last: 1'b1};
        phase_nxt = ufps_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = ufps_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ufps_pkg::PH_IDLE;
      cnt_r   <= '0;
      cmd_r   <= ufps_pkg::CMD_NONE;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
    pos_r  <= pos_nxt;
    ver_r  <= ver_nxt;
  end

  // ---------------------------------------------------------------- memory
  // Accepted ranges end within MEM_BYTES, so the low address bits suffice
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- result queue
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_result_kind    = fifo_r[rd_ptr_r].kind;
  assign out_tx_byte        = fifo_r[rd_ptr_r].tx;
  assign out_target_version = fifo_r[rd_ptr_r].ver;
  assign out_last_of_run    = fifo_r[rd_ptr_r].last;

endmodule

FILE: hdl/ufps_checker.sv
// Port-level checker for the UART flash protocol server, bound to the top level.
// Depends on ufps_pkg and uart_flash_protocol_server_defines.svh.
`include "uart_flash_protocol_server_defines.svh"

module ufps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [7:0]  out_tx_byte,
  input logic [31:0] out_target_version,
  input logic        out_last_of_run
);

  // A stalled result beat holds
  `UFPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_kind) && $stable(out_tx_byte) && $stable(out_target_version) && $stable(out_last_of_run), "result beat changed while stalled")

  // A version report closes its run and carries no transmit byte
  `UFPS_ASSERT_SAME(a_report_shape, clk, rst_n, out_valid && (out_result_kind == ufps_pkg::KIND_REPORT), out_last_of_run && (out_tx_byte == 8'h00), "malformed version report")

  `UFPS_ASSERT_SAME(a_tx_no_version, clk, rst_n, out_valid && (out_result_kind == ufps_pkg::KIND_TX), out_target_version == 32'h0, "transmit beat carries a version word")

  // Only an ack can be followed by another result of the same input byte
  `UFPS_ASSERT_SAME(a_mid_run_ack, clk, rst_n, out_valid && (out_result_kind == ufps_pkg::KIND_TX) && !out_last_of_run, out_tx_byte == ufps_pkg::ACK_BYTE, "non-final beat is not an ack")

endmodule

bind uart_flash_protocol_server ufps_checker u_ufps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_tx_byte        (out_tx_byte),
  .out_target_version (out_target_version),
  .out_last_of_run    (out_last_of_run)
);
